FILE: src/fmqd_pkg.sv
// shared constants, types and the arctangent table of the fm quadrature demodulator
package fmqd_pkg;

	// block sizing
	localparam int MAX_DECIMATION = 64;
	localparam int CORDIC_STAGES  = 16;

	// stream and configuration widths
	localparam int IQ_W       = 16;
	localparam int AUDIO_W    = 16;
	localparam int IDX_W      = 16;
	localparam int S_DATA_W   = 2 * IQ_W;
	localparam int M_DATA_W   = AUDIO_W + IDX_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DEC_W      = 7;
	localparam int COEFF_W    = 15;

	// datapath widths
	localparam int CORR_W   = IQ_W + 1;
	localparam int MUL_W    = 2 * CORR_W;
	localparam int PROD_W   = MUL_W + 1;
	localparam int XY_W     = 45;
	localparam int Z_W      = 25;
	localparam int NORM_TOP = 40;
	localparam int SHIFT_W  = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
	localparam int STEP_W   = 16;
	localparam int SUM_W    = STEP_W + $clog2(MAX_DECIMATION);
	localparam int CNT_W    = $clog2(MAX_DECIMATION + 1);
	localparam int QUO_W    = 16;
	localparam int DIV_W    = (SUM_W + 1 > CNT_W + QUO_W) ? SUM_W + 1 : CNT_W + QUO_W;
	localparam int DEEMPH_W = 16;

	// reset values and fixed scalings
	localparam logic [DEC_W-1:0]       DEC_RESET    = DEC_W'(1);
	localparam logic [COEFF_W-1:0]     COEFF_RESET  = COEFF_W'(31382);
	localparam logic signed [Z_W-1:0]  QUARTER_TURN = Z_W'(4194304);
	localparam logic signed [AUDIO_W-1:0] AUDIO_SCALE = AUDIO_W'(24000);

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DECIMATION,
		CFG_DC_OFFSET_I,
		CFG_DC_OFFSET_Q,
		CFG_DEEMPH_COEFF
	} cfg_idx_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_PRE,
		ST_NORM,
		ST_CORDIC,
		ST_ACC,
		ST_DIV,
		ST_DMUL,
		ST_DADD,
		ST_SCALE,
		ST_OUT
	} state_t;

	// vector moving through the cordic cells
	typedef struct packed {
		logic                   valid;
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} cordic_vec_t;

	// request to the averaging divider
	typedef struct packed {
		logic                    start;
		logic signed [SUM_W-1:0] dividend;
		logic [CNT_W-1:0]        divisor;
	} div_req_t;

	// rotation angle of each stage in units of pi/2^23
	function automatic logic signed [Z_W-1:0] atan_angle(input int unsigned k);
		logic signed [Z_W-1:0] a;
		case (k)
			0:  a = Z_W'(2097152);
			1:  a = Z_W'(1238021);
			2:  a = Z_W'(654136);
			3:  a = Z_W'(332050);
			4:  a = Z_W'(166669);
			5:  a = Z_W'(83416);
			6:  a = Z_W'(41718);
			7:  a = Z_W'(20860);
			8:  a = Z_W'(10430);
			9:  a = Z_W'(5215);
			10: a = Z_W'(2608);
			11: a = Z_W'(1304);
			12: a = Z_W'(652);
			13: a = Z_W'(326);
			14: a = Z_W'(163);
			15: a = Z_W'(81);
			16: a = Z_W'(41);
			17: a = Z_W'(20);
			18: a = Z_W'(10);
			19: a = Z_W'(5);
			20: a = Z_W'(3);
			21: a = Z_W'(1);
			22: a = Z_W'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

FILE: src/fmqd_cordic_cell.sv
// one vectoring cordic cell: a single micro-rotation, registered
module fmqd_cordic_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fmqd_pkg::cordic_vec_t         cin,
	input  logic [fmqd_pkg::SHIFT_W-1:0]  stage,
	input  logic signed [fmqd_pkg::Z_W-1:0] angle,
	output fmqd_pkg::cordic_vec_t         cout
);
	import fmqd_pkg::*;

	logic                   valid_q;
	logic signed [XY_W-1:0] x_q;
	logic signed [XY_W-1:0] y_q;
	logic signed [Z_W-1:0]  z_q;
	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;

	// floor shifts of the incoming vector
	assign xs = cin.x >>> stage;
	assign ys = cin.y >>> stage;

	// valid travels with the vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cin.valid;
		end
	end

	// rotate toward the x axis
	always_ff @(posedge clk) begin
		if (cin.valid) begin
			if (!cin.y[XY_W-1]) begin
				x_q <= cin.x + ys;
				y_q <= cin.y - xs;
				z_q <= cin.z + angle;
			end else begin
				x_q <= cin.x - ys;
				y_q <= cin.y + xs;
				z_q <= cin.z - angle;
			end
		end
	end

	assign cout = '{valid: valid_q, x: x_q, y: y_q, z: z_q};

endmodule

FILE: src/fmqd_cordic_chain.sv
// row of cordic cells, one stage per cell, angle accumulated along the row
module fmqd_cordic_chain (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fmqd_pkg::cordic_vec_t vin,
	output fmqd_pkg::cordic_vec_t vout
);
	import fmqd_pkg::*;

	cordic_vec_t link [CORDIC_STAGES+1];

	assign link[0] = vin;

	// each cell hands its vector to the next one every cycle
	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
		fmqd_cordic_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.cin   (link[k]),
			.stage (SHIFT_W'(k)),
			.angle (atan_angle(k)),
			.cout  (link[k+1])
		);
	end

	assign vout = link[CORDIC_STAGES];

endmodule

FILE: src/fmqd_divider.sv
// bit-serial restoring divider for the phase average, truncating toward zero
module fmqd_divider (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fmqd_pkg::div_req_t                  req,
	output logic                                done,
	output logic signed [fmqd_pkg::QUO_W-1:0]   quotient
);
	import fmqd_pkg::*;

	localparam int STEP_CNT_W = $clog2(QUO_W);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_CNT_W-1:0] step_q;
	logic                  neg_q;
	logic [DIV_W-1:0]      rem_q;
	logic [DIV_W-1:0]      den_q;
	logic [QUO_W-1:0]      quo_q;
	logic [SUM_W:0]        dvd_ext;
	logic [SUM_W:0]        dvd_mag;
	logic                  fits;

	// magnitude of the dividend, one bit wider so the most negative sum fits
	assign dvd_ext = {req.dividend[SUM_W-1], req.dividend};
	assign dvd_mag = req.dividend[SUM_W-1] ? (~dvd_ext + 1'b1) : dvd_ext;
	assign fits    = rem_q >= den_q;

	// step counter, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == '0) && !req.start;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_CNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// compare and subtract against the shifted divisor
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[SUM_W-1];
			rem_q <= DIV_W'(dvd_mag);
			den_q <= DIV_W'(req.divisor) << (QUO_W - 1);
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - den_q;
			end
			den_q <= den_q >> 1;
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? $signed(-quo_q) : $signed(quo_q);

endmodule

FILE: src/fm_quadrature_demodulator.sv
// fm quadrature demodulator top level: sequencer, discriminator, averaging, de-emphasis
//
// Input stream s_*: one I/Q pair per transfer, s_tdata = {q_sample, i_sample},
// s_tuser = first_of_buffer (clears phase sum, step count and output index).
// Output stream m_*: one audio sample per completed decimation group,
// m_tdata = {out_index, audio_sample}.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (decimation, dc_offset_i, dc_offset_q, deemph_coeff); write only while idle.
// One item is in flight at a time. From its transfer until the next s_tready an
// item passes through the conjugate product and the quadrant pre-rotation
// (four parallel 17x17 multipliers), block normalization, the cordic cell row
// and the accumulation; a zero product skips normalization and the row. An item
// that completes a group then goes through the bit-serial divider, de-emphasis,
// scaling and loading of the output register.
// The output register decouples the two sides: the next item is taken while a
// result waits; only a second finished result waits for m_tready.
// Reset clears the configuration to its defaults (decimation 1, offsets 0,
// coefficient 31382), the filter state, the sums and the output index.
module fm_quadrature_demodulator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [fmqd_pkg::S_DATA_W-1:0]     s_tdata,   // i_sample [15:0], q_sample [31:16]
	input  logic                              s_tuser,   // first_of_buffer
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [fmqd_pkg::M_DATA_W-1:0]     m_tdata,   // audio_sample [15:0], out_index [31:16]
	input  logic                              cfg_we,
	input  logic [fmqd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fmqd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import fmqd_pkg::*;

	localparam int CMP_W   = (DEC_W > CNT_W) ? DEC_W : CNT_W;
	localparam int NSH_W   = 4;
	localparam int WOLD_W  = COEFF_W + 2;
	localparam int MOLD_W  = DEEMPH_W + WOLD_W;
	localparam int MNEW_W  = DEEMPH_W + COEFF_W + 1;
	localparam int ACC_W   = MOLD_W + 1;
	localparam int SCL_W   = DEEMPH_W + AUDIO_W;

	localparam logic [XY_W-1:0] LIM1 = XY_W'(1) << NORM_TOP;
	localparam logic [XY_W-1:0] LIM2 = XY_W'(1) << (NORM_TOP - 1);
	localparam logic [XY_W-1:0] LIM4 = XY_W'(1) << (NORM_TOP - 3);
	localparam logic [XY_W-1:0] LIM8 = XY_W'(1) << (NORM_TOP - 7);

	localparam logic signed [Z_W:0]    ROUND_Z   = (Z_W + 1)'(128);
	localparam logic signed [Z_W:0]    STEP_MAX  = (Z_W + 1)'((1 << (STEP_W - 1)) - 1);
	localparam logic signed [Z_W:0]    STEP_MIN  = -((Z_W + 1)'(1) << (STEP_W - 1));
	localparam logic signed [WOLD_W-1:0] W_ONE   = WOLD_W'(1) << COEFF_W;
	localparam logic signed [ACC_W-1:0]  ROUND_D = ACC_W'(1) << (COEFF_W - 1);
	localparam logic signed [SCL_W-1:0]  TRUNC_B = SCL_W'((1 << COEFF_W) - 1);
	localparam logic [CMP_W-1:0]       DEC_MAX   = CMP_W'(MAX_DECIMATION);

	// sequencer
	state_t state_q;
	state_t state_d;

	// control strobes
	logic accept;
	logic chain_start;
	logic div_start;
	logic out_load;
	logic out_free;

	// configuration registers
	logic [DEC_W-1:0]        dec_q;
	logic signed [IQ_W-1:0]  dc_i_q;
	logic signed [IQ_W-1:0]  dc_q_q;
	logic [COEFF_W-1:0]      coeff_q;

	// block state
	logic signed [CORR_W-1:0]   prev_i_q;
	logic signed [CORR_W-1:0]   prev_q_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]           count_q;
	logic signed [DEEMPH_W-1:0] deemph_q;
	logic [IDX_W-1:0]           out_cnt_q;

	// working registers
	logic signed [CORR_W-1:0]   ci_q;
	logic signed [CORR_W-1:0]   cq_q;
	logic signed [MUL_W-1:0]    p_ii_q;
	logic signed [MUL_W-1:0]    p_qq_q;
	logic signed [MUL_W-1:0]    p_qi_q;
	logic signed [MUL_W-1:0]    p_iq_q;
	logic signed [PROD_W-1:0]   di_q;
	logic signed [PROD_W-1:0]   dq_q;
	logic signed [XY_W-1:0]     x_q;
	logic signed [XY_W-1:0]     y_q;
	logic signed [Z_W-1:0]      z_q;
	logic signed [STEP_W-1:0]   step_q;
	logic signed [QUO_W-1:0]    avg_q;
	logic signed [MOLD_W-1:0]   m_old_q;
	logic signed [MNEW_W-1:0]   m_new_q;
	logic signed [SCL_W-1:0]    scale_q;
	logic [AUDIO_W-1:0]         audio_q;
	logic [IDX_W-1:0]           index_q;
	logic                       m_valid_q;

	// combinational datapath
	logic signed [CORR_W-1:0] ci_d;
	logic signed [CORR_W-1:0] cq_d;
	logic signed [XY_W-1:0]   di_x;
	logic signed [XY_W-1:0]   dq_x;
	logic                     prod_zero;
	logic [XY_W-1:0]          y_mag;
	logic [XY_W-1:0]          m_mag;
	logic                     norm_done;
	logic [NSH_W-1:0]         norm_sh;
	logic signed [Z_W:0]      z_round;
	logic signed [Z_W:0]      z_shift;
	logic signed [STEP_W-1:0] step_d;
	logic [CMP_W-1:0]         dec_raw;
	logic [CMP_W-1:0]         dec_eff;
	logic [CNT_W-1:0]         cnt_inc;
	logic signed [SUM_W-1:0]  sum_nxt;
	logic                     dec_hit;
	logic signed [WOLD_W-1:0] w_old;
	logic signed [ACC_W-1:0]  acc_d;
	logic signed [SCL_W-1:0]  scale_b;

	cordic_vec_t chain_in;
	cordic_vec_t chain_out;
	div_req_t    div_req;
	logic        div_done;
	logic signed [QUO_W-1:0] div_quo;

	// offset removal on the incoming pair
	assign ci_d = $signed({s_tdata[IQ_W-1], s_tdata[IQ_W-1:0]}) - $signed({dc_i_q[IQ_W-1], dc_i_q});
	assign cq_d = $signed({s_tdata[S_DATA_W-1], s_tdata[S_DATA_W-1:IQ_W]})
	            - $signed({dc_q_q[IQ_W-1], dc_q_q});

	// quadrant pre-rotation inputs
	assign di_x      = XY_W'(di_q);
	assign dq_x      = XY_W'(dq_q);
	assign prod_zero = (di_q == '0) && (dq_q == '0);

	// block normalization: largest doubling count that keeps below twice the target
	assign y_mag     = y_q[XY_W-1] ? XY_W'(-y_q) : XY_W'(y_q);
	assign m_mag     = (XY_W'(x_q) > y_mag) ? XY_W'(x_q) : y_mag;
	assign norm_done = m_mag >= LIM1;
	always_comb begin
		if (m_mag < LIM8) begin
			norm_sh = NSH_W'(8);
		end else if (m_mag < LIM4) begin
			norm_sh = NSH_W'(4);
		end else if (m_mag < LIM2) begin
			norm_sh = NSH_W'(2);
		end else begin
			norm_sh = NSH_W'(1);
		end
	end

	// round the angle to q15 units of pi and clamp
	assign z_round = (Z_W + 1)'(chain_out.z) + ROUND_Z;
	assign z_shift = z_round >>> 8;
	always_comb begin
		if (z_shift > STEP_MAX) begin
			step_d = STEP_W'(STEP_MAX);
		end else if (z_shift < STEP_MIN) begin
			step_d = STEP_W'(STEP_MIN);
		end else begin
			step_d = STEP_W'(z_shift);
		end
	end

	// effective decimation and group completion
	assign dec_raw = CMP_W'(dec_q);
	always_comb begin
		if (dec_raw == '0) begin
			dec_eff = CMP_W'(1);
		end else if (dec_raw > DEC_MAX) begin
			dec_eff = DEC_MAX;
		end else begin
			dec_eff = dec_raw;
		end
	end
	assign cnt_inc = count_q + 1'b1;
	assign sum_nxt = sum_q + SUM_W'(step_q);
	assign dec_hit = CMP_W'(cnt_inc) >= dec_eff;

	// de-emphasis and output scaling
	assign w_old   = W_ONE - $signed({2'b00, coeff_q});
	assign acc_d   = ACC_W'(m_old_q) + ACC_W'(m_new_q) + ROUND_D;
	assign scale_b = scale_q + (scale_q[SCL_W-1] ? TRUNC_B : '0);

	assign out_free = !m_valid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_MUL;
			ST_MUL:    state_d = ST_SUM;
			ST_SUM:    state_d = ST_PRE;
			ST_PRE:    state_d = prod_zero ? ST_ACC : ST_NORM;
			ST_NORM:   if (norm_done) state_d = ST_CORDIC;
			ST_CORDIC: if (chain_out.valid) state_d = ST_ACC;
			ST_ACC:    state_d = dec_hit ? ST_DIV : ST_IDLE;
			ST_DIV:    if (div_done) state_d = ST_DMUL;
			ST_DMUL:   state_d = ST_DADD;
			ST_DADD:   state_d = ST_SCALE;
			ST_SCALE:  state_d = ST_OUT;
			ST_OUT:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready    = 1'b0;
		chain_start = 1'b0;
		div_start   = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			ST_IDLE: s_tready    = 1'b1;
			ST_NORM: chain_start = norm_done;
			ST_ACC:  div_start   = dec_hit;
			ST_OUT:  out_load    = out_free;
			default: ;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes, block state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q     <= DEC_RESET;
			dc_i_q    <= '0;
			dc_q_q    <= '0;
			coeff_q   <= COEFF_RESET;
			prev_i_q  <= '0;
			prev_q_q  <= '0;
			sum_q     <= '0;
			count_q   <= '0;
			deemph_q  <= '0;
			out_cnt_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DECIMATION:   dec_q   <= cfg_data[DEC_W-1:0];
					CFG_DC_OFFSET_I:  dc_i_q  <= cfg_data[IQ_W-1:0];
					CFG_DC_OFFSET_Q:  dc_q_q  <= cfg_data[IQ_W-1:0];
					CFG_DEEMPH_COEFF: coeff_q <= cfg_data[COEFF_W-1:0];
					default: ;
				endcase
			end
			// start of a new buffer
			if (accept && s_tuser) begin
				sum_q     <= '0;
				count_q   <= '0;
				out_cnt_q <= '0;
			end
			if (state_q == ST_MUL) begin
				prev_i_q <= ci_q;
				prev_q_q <= cq_q;
			end
			// accumulate the step, or hand the group to the divider
			if (state_q == ST_ACC) begin
				if (dec_hit) begin
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					sum_q   <= sum_nxt;
					count_q <= cnt_inc;
				end
			end
			if (state_q == ST_DADD) begin
				deemph_q <= acc_d[COEFF_W +: DEEMPH_W];
			end
			// output register and saturating index
			if (out_load) begin
				m_valid_q <= 1'b1;
				if (out_cnt_q != '1) begin
					out_cnt_q <= out_cnt_q + 1'b1;
				end
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// working datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ci_q <= ci_d;
			cq_q <= cq_d;
		end
		// conjugate product terms
		if (state_q == ST_MUL) begin
			p_ii_q <= ci_q * prev_i_q;
			p_qq_q <= cq_q * prev_q_q;
			p_qi_q <= cq_q * prev_i_q;
			p_iq_q <= ci_q * prev_q_q;
		end
		if (state_q == ST_SUM) begin
			di_q <= PROD_W'(p_ii_q) + PROD_W'(p_qq_q);
			dq_q <= PROD_W'(p_qi_q) - PROD_W'(p_iq_q);
		end
		// quadrant pre-rotation
		if (state_q == ST_PRE) begin
			step_q <= '0;
			if (di_x < 0) begin
				if (dq_x >= 0) begin
					x_q <= dq_x;
					y_q <= -di_x;
					z_q <= QUARTER_TURN;
				end else begin
					x_q <= -dq_x;
					y_q <= di_x;
					z_q <= -QUARTER_TURN;
				end
			end else begin
				x_q <= di_x;
				y_q <= dq_x;
				z_q <= '0;
			end
		end
		if (state_q == ST_NORM && !norm_done) begin
			x_q <= x_q <<< norm_sh;
			y_q <= y_q <<< norm_sh;
		end
		if (state_q == ST_CORDIC && chain_out.valid) begin
			step_q <= step_d;
		end
		if (state_q == ST_DIV && div_done) begin
			avg_q <= div_quo;
		end
		// de-emphasis products
		if (state_q == ST_DMUL) begin
			m_old_q <= deemph_q * w_old;
			m_new_q <= avg_q * $signed({1'b0, coeff_q});
		end
		if (state_q == ST_SCALE) begin
			scale_q <= deemph_q * AUDIO_SCALE;
		end
		if (out_load) begin
			audio_q <= scale_b[COEFF_W +: AUDIO_W];
			index_q <= out_cnt_q;
		end
	end

	// angle measurement
	assign chain_in = '{valid: chain_start, x: x_q, y: y_q, z: z_q};

	fmqd_cordic_chain u_chain (
		.clk   (clk),
		.arst_n(arst_n),
		.vin   (chain_in),
		.vout  (chain_out)
	);

	// group average
	assign div_req = '{start: div_start, dividend: sum_nxt, divisor: cnt_inc};

	fmqd_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.done    (div_done),
		.quotient(div_quo)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {index_q, audio_q};

endmodule

FILE: src/fmqd_checker.sv
// port-level checks of the fm quadrature demodulator, bound to the top level
module fmqd_port_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [fmqd_pkg::M_DATA_W-1:0]     m_tdata
);
	import fmqd_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped while stalled");

	// one item at a time: busy right after a transfer in
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in flight");

	// no result can appear right after an input transfer
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared too early");

	// scaled audio stays inside the full-scale range
	a_audio_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[AUDIO_W-1:0]) >= -AUDIO_SCALE)
		          && ($signed(m_tdata[AUDIO_W-1:0]) <= AUDIO_SCALE))
		else $error("audio sample out of range");

endmodule

bind fm_quadrature_demodulator fmqd_port_checker u_port_checker (.*);

FILE: bench/fmqd_checker.sv
// transfer monitor, demodulator predictor and result comparison for the fm quadrature demodulator
`timescale 1ns / 100ps

module fmqd_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [fmqd_pkg::S_DATA_W-1:0]   s_tdata,   // i_sample [15:0], q_sample [31:16]
	input  logic                            s_tuser,   // first_of_buffer
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [fmqd_pkg::M_DATA_W-1:0]   m_tdata,   // audio_sample [15:0], out_index [31:16]
	input  logic                            cfg_we,
	input  logic [fmqd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fmqd_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatches,
	output int                              outstanding
);

	import fmqd_pkg::*;

	// one audio result, laid out like m_tdata
	typedef struct packed {
		logic [IDX_W-1:0]   index;
		logic [AUDIO_W-1:0] audio;
	} audio_out_t;

	localparam longint NORM_LIMIT  = 64'sd1099511627776;
	localparam longint HALF_PI_Z   = 64'sd4194304;
	localparam int     AUDIO_GAIN  = 24000;
	localparam int     INDEX_LIMIT = 65535;

	// cordic rotation angles in units of pi/2^23
	longint rot_angle [24] = '{
		2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
		10430, 5215, 2608, 1304, 652, 326, 163, 81,
		41, 20, 10, 5, 3, 1, 1, 0
	};

	// configuration copy
	logic [DEC_W-1:0]   decim;
	shortint            off_i;
	shortint            off_q;
	logic [COEFF_W-1:0] weight;

	// demodulator state copy
	longint prev_i, prev_q;
	longint step_sum;
	int     step_cnt;
	int     filt;
	int     out_pos;

	audio_out_t audio_due [$];
	int         errs;

	// phase of the conjugate product as a q15 fraction of pi
	function automatic int phase_step_q15(input longint x, input longint y);
		longint z, t, xs, ys, q;
		if (x == 0 && y == 0)
			return 0;
		z = 0;
		// rotate into the right half plane
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = HALF_PI_Z;
			end else begin
				t = x; x = -y; y = t; z = -HALF_PI_Z;
			end
		end
		// scale up until one component reaches the normalization limit
		while ((x < 0 ? -x : x) < NORM_LIMIT && (y < 0 ? -y : y) < NORM_LIMIT) begin
			x = x * 2;
			y = y * 2;
		end
		for (int k = 0; k < CORDIC_STAGES && k < 24; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z = z + rot_angle[k];
			end else begin
				x = x - ys; y = y + xs; z = z - rot_angle[k];
			end
		end
		q = (z + 128) >>> 8;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return int'(q);
	endfunction

	// advance the demodulator by one i/q pair; returns 1 when an audio sample is due
	function automatic bit demod_step(input shortint i_s, input shortint q_s, input bit first,
			output audio_out_t res);
		longint ci, cq, di, dq, acc, avg;
		int     lim;
		res = '0;
		if (first) begin
			step_sum = 0;
			step_cnt = 0;
			out_pos  = 0;
		end
		ci = longint'(i_s) - longint'(off_i);
		cq = longint'(q_s) - longint'(off_q);
		di = ci * prev_i + cq * prev_q;
		dq = cq * prev_i - ci * prev_q;
		prev_i = ci;
		prev_q = cq;
		step_sum = step_sum + phase_step_q15(di, dq);
		step_cnt++;
		// zero acts as one, oversize values clip to the maximum
		lim = int'(decim);
		if (lim == 0) lim = 1;
		if (lim > MAX_DECIMATION) lim = MAX_DECIMATION;
		if (step_cnt < lim)
			return 1'b0;
		avg = step_sum / longint'(step_cnt);
		acc = longint'(filt) * (32768 - longint'(weight)) + avg * longint'(weight) + 16384;
		filt = int'(acc >>> 15);
		res.audio = AUDIO_W'((longint'(filt) * AUDIO_GAIN) / 32768);
		res.index = IDX_W'(out_pos);
		if (out_pos < INDEX_LIMIT)
			out_pos++;
		step_sum = 0;
		step_cnt = 0;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		audio_out_t got, want, pred;
		if (!arst_n) begin
			decim    = DEC_RESET;
			off_i    = 0;
			off_q    = 0;
			weight   = COEFF_RESET;
			prev_i   = 0;
			prev_q   = 0;
			step_sum = 0;
			step_cnt = 0;
			filt     = 0;
			out_pos  = 0;
			errs     = 0;
			audio_due.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_DECIMATION:   decim  = cfg_data[DEC_W-1:0];
					CFG_DC_OFFSET_I:  off_i  = shortint'(cfg_data);
					CFG_DC_OFFSET_Q:  off_q  = shortint'(cfg_data);
					CFG_DEEMPH_COEFF: weight = cfg_data[COEFF_W-1:0];
					default: ;
				endcase
			end
			// output transfer against the oldest prediction
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (audio_due.size() == 0) begin
					$error("unexpected audio transfer: audio_sample %0d, out_index %0d",
						$signed(got.audio), got.index);
					errs++;
				end else begin
					want = audio_due.pop_front();
					if (got.audio !== want.audio) begin
						$error("audio_sample mismatch: expected %0d, actual %0d",
							$signed(want.audio), $signed(got.audio));
						errs++;
					end
					if (got.index !== want.index) begin
						$error("out_index mismatch: expected %0d, actual %0d",
							want.index, got.index);
						errs++;
					end
				end
			end
			// input transfer feeds the predictor
			if (s_tvalid && s_tready) begin
				if (demod_step(shortint'(s_tdata[IQ_W-1:0]), shortint'(s_tdata[S_DATA_W-1:IQ_W]),
						s_tuser, pred))
					audio_due.push_back(pred);
			end
			mismatches  <= errs;
			outstanding <= audio_due.size();
		end
	end

endmodule

FILE: bench/fm_quadrature_demodulator_tb.sv
// stimulus, flow control and verdict for the fm quadrature demodulator
`timescale 1ns / 100ps

module fm_quadrature_demodulator_tb;

	import fmqd_pkg::*;

	localparam int     STALL_LIMIT  = 5000;
	localparam int     DRAIN_CYCLES = 64;
	localparam int     PHASE_ITEMS  = 112;
	localparam real    PI_R         = 3.14159265358979;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int  mismatches;
	int  outstanding;
	int  idle_cycles;
	int  burst_left;
	int  cur_off_i, cur_off_q;
	real tone_ph, tone_dph, tone_amp;

	fm_quadrature_demodulator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fmqd_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver back-pressure, switching between patterns
	initial begin : rx_pattern
		int mode, span;
		m_tready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = (mode == 3) ? $urandom_range(1, 40) : $urandom_range(10, 150);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 5) == 0);
					default: m_tready <= 1'b0;
				endcase
			end
		end
	end

	function automatic shortint sat16(input int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return shortint'(v);
	endfunction

	// one i/q transfer, with bursts and random gaps ahead of it
	task automatic push_iq(input shortint i_s, input shortint q_s, input bit first);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 40);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {q_s, i_s};
		s_tuser  <= first;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and let the block drain completely
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write all four registers, block idle
	task automatic configure(input int dec, input int oi, input int oq, input int coeff);
		cfg_we <= 1'b1;
		cfg_index <= CFG_DECIMATION;   cfg_data <= CFG_DATA_W'(dec);   @(posedge clk);
		cfg_index <= CFG_DC_OFFSET_I;  cfg_data <= CFG_DATA_W'(oi);    @(posedge clk);
		cfg_index <= CFG_DC_OFFSET_Q;  cfg_data <= CFG_DATA_W'(oq);    @(posedge clk);
		cfg_index <= CFG_DEEMPH_COEFF; cfg_data <= CFG_DATA_W'(coeff); @(posedge clk);
		cfg_we <= 1'b0;
		cur_off_i = oi;
		cur_off_q = oq;
	endtask

	task automatic new_tone();
		tone_dph = (real'($urandom_range(0, 2000)) - 1000.0) * 0.0031;
		tone_amp = real'($urandom_range(20, 32767));
	endtask

	// mostly a clean carrier around the offsets, plus noise, tiny and zero samples
	task automatic random_item();
		int      kind;
		shortint i_s, q_s;
		kind = $urandom_range(0, 99);
		if (kind < 55) begin
			if ($urandom_range(0, 39) == 0)
				new_tone();
			tone_ph = tone_ph + tone_dph;
			if (tone_ph > PI_R) tone_ph = tone_ph - 2.0 * PI_R;
			if (tone_ph < -PI_R) tone_ph = tone_ph + 2.0 * PI_R;
			i_s = sat16(cur_off_i + $rtoi(tone_amp * $cos(tone_ph)));
			q_s = sat16(cur_off_q + $rtoi(tone_amp * $sin(tone_ph)));
		end else if (kind < 80) begin
			i_s = shortint'($urandom());
			q_s = shortint'($urandom());
		end else if (kind < 92) begin
			i_s = sat16(cur_off_i + $urandom_range(0, 8) - 4);
			q_s = sat16(cur_off_q + $urandom_range(0, 8) - 4);
		end else begin
			i_s = shortint'(cur_off_i);
			q_s = shortint'(cur_off_q);
		end
		push_iq(i_s, q_s, $urandom_range(0, 29) == 0);
	endtask

	initial begin : stimulus
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_DECIMATION;
		cfg_data  = '0;
		burst_left = 0;
		cur_off_i = 0;
		cur_off_q = 0;
		tone_ph   = 0.0;
		new_tone();
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: quadrants, extremes, tiny and zero products
		push_iq(0, 0, 1'b1);
		push_iq(32767, 0, 1'b0);
		push_iq(0, 32767, 1'b0);
		push_iq(-32768, 0, 1'b0);
		push_iq(0, -32768, 1'b0);
		push_iq(-32768, -32768, 1'b0);
		push_iq(32767, 32767, 1'b0);
		push_iq(-32768, 32767, 1'b0);
		push_iq(32767, -32768, 1'b0);
		push_iq(1, 0, 1'b0);
		// exact half turn, angle clamps at the top
		push_iq(-1, 0, 1'b0);
		push_iq(0, 0, 1'b0);
		push_iq(100, -7, 1'b1);
		push_iq(100, -7, 1'b0);
		settle();

		// decimation zero, extreme offsets, coefficient zero
		configure(0, 32767, -32768, 0);
		push_iq(-32768, 32767, 1'b0);
		push_iq(32767, -32768, 1'b0);
		push_iq(-32768, -32768, 1'b1);
		settle();

		// decimation lowered while a partial sum is pending
		configure(8, 0, 0, 20000);
		push_iq(1000, 0, 1'b1);
		push_iq(700, 700, 1'b0);
		push_iq(0, 1000, 1'b0);
		push_iq(-700, 700, 1'b0);
		push_iq(-1000, 0, 1'b0);
		settle();
		configure(3, 0, 0, 20000);
		push_iq(-700, -700, 1'b0);
		settle();

		// random phases over a spread of settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: configure(1, -32768, 32767, 0);
				1: configure(64, 0, 0, 32767);
				2: configure(127, int'(shortint'($urandom())), int'(shortint'($urandom())),
					$urandom_range(0, 32767));
				3: configure(0, 32767, -32768, 31382);
				default: configure($urandom_range(1, 10), $urandom_range(0, 2000) - 1000,
					$urandom_range(0, 2000) - 1000, $urandom_range(0, 32767));
			endcase
			new_tone();
			repeat (PHASE_ITEMS) random_item();
			settle();
		end

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
